### sv/actuator_position_controller_macros.svh
`ifndef ACTUATOR_POSITION_CONTROLLER_MACROS_SVH
`define ACTUATOR_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication check, off during reset
`define APC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("apc: same-cycle check failed");

// Next-cycle implication check, off during reset
`define APC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("apc: next-cycle check failed");

`endif

### sv/apc_pkg.sv
`default_nettype none
package apc_pkg;

	// Reading and length limits
	localparam int unsigned SAMPLES_PER_READING = 10;
	localparam int unsigned MAX_LENGTH_MM       = 150;

	localparam int unsigned NW   = $clog2(SAMPLES_PER_READING + 1);
	localparam int unsigned CNTW = 4;
	localparam int unsigned SUMW = 20;
	localparam int unsigned DIVW = 16 + NW;
	localparam int unsigned DIFW = (DIVW > SUMW) ? DIVW : SUMW;
	localparam int unsigned QW   = 16;
	localparam int unsigned STPW = $clog2(QW);

	localparam logic [NW-1:0] N_SMP       = NW'(SAMPLES_PER_READING);
	localparam logic [15:0]   MAX_LEN_Q   = 16'(MAX_LENGTH_MM * 256);
	localparam logic [15:0]   SLOW_ZONE_Q = 16'(15 * 256);

	localparam logic [7:0] PWM_STOP = 8'd0;
	localparam logic [7:0] PWM_SLOW = 8'd76;
	localparam logic [7:0] PWM_FULL = 8'd255;

	localparam logic DIR_RETRACT = 1'b0;
	localparam logic DIR_EXTEND  = 1'b1;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_START  = 1'b1;

	// Register indexes
	localparam logic [2:0] REG_TARGET_A = 3'd0;
	localparam logic [2:0] REG_TARGET_B = 3'd1;
	localparam logic [2:0] REG_POTMIN_A = 3'd2;
	localparam logic [2:0] REG_POTMIN_B = 3'd3;
	localparam logic [2:0] REG_SCALE_A  = 3'd4;
	localparam logic [2:0] REG_SCALE_B  = 3'd5;
	localparam logic [2:0] REG_TOL_A    = 3'd6;
	localparam logic [2:0] REG_TOL_B    = 3'd7;

	typedef struct packed {
		logic [1:0][15:0] target;
		logic [1:0][15:0] pot_min;
		logic [1:0][15:0] scale;
		logic [1:0][15:0] tol;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic prep;
		logic chk;
		logic div_step;
		logic fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic start_calc;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### sv/apc_regs.sv
`default_nettype none
module apc_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output apc_pkg::cfg_t     cfg
);

	logic [2:0]  idx;
	logic        wr_en;
	logic [15:0] rd_val;

	logic [1:0][15:0] target_q;
	logic [1:0][15:0] pot_min_q;
	logic [1:0][15:0] scale_q;
	logic [1:0][15:0] tol_q;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			pot_min_q <= '0;
			scale_q   <= {16'd256, 16'd256};
			tol_q     <= {16'd256, 16'd256};
		end else if (wr_en) begin
			unique case (idx)
				apc_pkg::REG_TARGET_A: target_q[0]  <= pwdata[15:0];
				apc_pkg::REG_TARGET_B: target_q[1]  <= pwdata[15:0];
				apc_pkg::REG_POTMIN_A: pot_min_q[0] <= pwdata[15:0];
				apc_pkg::REG_POTMIN_B: pot_min_q[1] <= pwdata[15:0];
				apc_pkg::REG_SCALE_A:  scale_q[0]   <= pwdata[15:0];
				apc_pkg::REG_SCALE_B:  scale_q[1]   <= pwdata[15:0];
				apc_pkg::REG_TOL_A:    tol_q[0]     <= pwdata[15:0];
				apc_pkg::REG_TOL_B:    tol_q[1]     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			apc_pkg::REG_TARGET_A: rd_val = target_q[0];
			apc_pkg::REG_TARGET_B: rd_val = target_q[1];
			apc_pkg::REG_POTMIN_A: rd_val = pot_min_q[0];
			apc_pkg::REG_POTMIN_B: rd_val = pot_min_q[1];
			apc_pkg::REG_SCALE_A:  rd_val = scale_q[0];
			apc_pkg::REG_SCALE_B:  rd_val = scale_q[1];
			apc_pkg::REG_TOL_A:    rd_val = tol_q[0];
			apc_pkg::REG_TOL_B:    rd_val = tol_q[1];
			default:               rd_val = '0;
		endcase
	end

	assign prdata      = {16'd0, rd_val};
	assign cfg.target  = target_q;
	assign cfg.pot_min = pot_min_q;
	assign cfg.scale   = scale_q;
	assign cfg.tol     = tol_q;

endmodule
`default_nettype wire

### sv/apc_ctrl.sv
`default_nettype none
module apc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire apc_pkg::sts_t sts,
	output apc_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_DEC  = 3'd5;

	logic [2:0]                  state_q;
	logic [2:0]                  state_d;
	logic [apc_pkg::STPW-1:0]    step_q;
	logic                        last_step;

	assign last_step = (step_q == apc_pkg::STPW'(apc_pkg::QW - 1));
	assign s_tready  = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = s_tvalid;
				if (s_tvalid && sts.start_calc) state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				cmd.emit = sts.out_free;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) step_q <= step_q + 1'b1;
			else step_q <= '0;
		end
	end

endmodule
`default_nettype wire

### sv/apc_dp.sv
`default_nettype none
`include "actuator_position_controller_macros.svh"
module apc_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire apc_pkg::cfg_t cfg,
	input  wire apc_pkg::cmd_t cmd,
	output apc_pkg::sts_t      sts,
	input  wire logic [15:0]   s_tdata,
	input  wire logic [1:0]    s_tuser,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [31:0]        m_tdata,
	output logic               m_tuser
);

	localparam int unsigned CW = apc_pkg::CNTW + 1;

	logic                          in_action;
	logic                          in_act;
	logic [CW-1:0]                 cnt_inc;
	logic                          full;
	logic [apc_pkg::SUMW-1:0]      sum_new;

	logic [1:0][apc_pkg::CNTW-1:0] cnt_q;
	logic [1:0][apc_pkg::SUMW-1:0] sum_q;
	logic [1:0]                    arr_q;

	logic                          act_q;
	logic [apc_pkg::SUMW-1:0]      calc_sum_q;
	logic [apc_pkg::DIVW-1:0]      base_q;
	logic [apc_pkg::DIVW-1:0]      div_q;
	logic [apc_pkg::DIFW-1:0]      rem_q;
	logic [apc_pkg::QW-1:0]        quo_q;
	logic                          zero_q;
	logic                          sat_q;
	logic [15:0]                   len_q;

	logic [apc_pkg::DIVW-1:0]      pmin_x;
	logic [apc_pkg::DIVW-1:0]      scl_x;
	logic [apc_pkg::DIVW-1:0]      n_x;
	logic [15:0]                   scl_nz;
	logic [apc_pkg::DIFW-1:0]      sum_x;
	logic [apc_pkg::DIFW-1:0]      base_x;
	logic [apc_pkg::DIFW-1:0]      dif;
	logic [apc_pkg::DIFW:0]        rem2;
	logic [apc_pkg::DIFW:0]        div_x;
	logic                          ge;

	logic [15:0]                   tgt;
	logic                          tgt_gt;
	logic [15:0]                   diff;
	logic                          hit;

	logic                          out_vld_q;
	logic                          out_act_q;
	logic                          out_dir_q;
	logic [7:0]                    out_pwm_q;
	logic                          out_arr_q;
	logic [15:0]                   out_len_q;

	// Decode the incoming transaction
	assign in_action = s_tuser[0];
	assign in_act    = s_tuser[1];
	assign cnt_inc   = {1'b0, cnt_q[in_act]} + CW'(1);
	assign full      = (cnt_inc >= CW'(apc_pkg::SAMPLES_PER_READING));
	assign sum_new   = sum_q[in_act] + apc_pkg::SUMW'(s_tdata);

	assign sts.start_calc = (in_action == apc_pkg::ACT_SAMPLE) && !arr_q[in_act] && full;
	assign sts.out_free   = !out_vld_q || m_tready;

	// Accumulate samples; clear all on start move; drop samples once arrived
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			arr_q <= '0;
		end else begin
			if (cmd.take) begin
				if (in_action == apc_pkg::ACT_START) begin
					cnt_q <= '0;
					sum_q <= '0;
					arr_q <= '0;
				end else if (!arr_q[in_act]) begin
					if (full) begin
						cnt_q[in_act] <= '0;
						sum_q[in_act] <= '0;
					end else begin
						cnt_q[in_act] <= cnt_inc[apc_pkg::CNTW-1:0];
						sum_q[in_act] <= sum_new;
					end
				end
			end
			if (cmd.emit && hit) arr_q[act_q] <= 1'b1;
		end
	end

	// Capture the finished reading
	always_ff @(posedge clk) begin
		if (cmd.take && sts.start_calc) begin
			act_q      <= in_act;
			calc_sum_q <= sum_new;
		end
	end

	// Offset and divisor scaled by the sample count
	assign scl_nz = (cfg.scale[act_q] == 16'd0) ? 16'd1 : cfg.scale[act_q];
	assign pmin_x = apc_pkg::DIVW'(cfg.pot_min[act_q]);
	assign scl_x  = apc_pkg::DIVW'(scl_nz);
	assign n_x    = apc_pkg::DIVW'(apc_pkg::N_SMP);

	assign sum_x  = apc_pkg::DIFW'(calc_sum_q);
	assign base_x = apc_pkg::DIFW'(base_q);
	assign dif    = sum_x - base_x;
	assign div_x  = (apc_pkg::DIFW + 1)'(div_q);
	assign rem2   = {rem_q, 1'b0};
	assign ge     = (rem2 >= div_x);

	// Restoring divide: one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			base_q <= pmin_x * n_x;
			div_q  <= scl_x * n_x;
		end
		if (cmd.chk) begin
			zero_q <= (sum_x <= base_x);
			sat_q  <= (dif >= apc_pkg::DIFW'(div_q));
			rem_q  <= dif;
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? apc_pkg::DIFW'(rem2 - div_x) : apc_pkg::DIFW'(rem2);
			quo_q <= {quo_q[apc_pkg::QW-2:0], ge};
		end
		if (cmd.fin) begin
			priority if (zero_q) len_q <= '0;
			else if (sat_q || quo_q > apc_pkg::MAX_LEN_Q) len_q <= apc_pkg::MAX_LEN_Q;
			else len_q <= quo_q;
		end
	end

	// Compare with target and tolerance
	assign tgt    = cfg.target[act_q];
	assign tgt_gt = (tgt > len_q);
	assign diff   = tgt_gt ? (tgt - len_q) : (len_q - tgt);
	assign hit    = (diff < cfg.tol[act_q]);

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (cmd.emit) out_vld_q <= 1'b1;
		else if (m_tready) out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_act_q <= act_q;
			out_len_q <= len_q;
			out_arr_q <= hit;
			if (hit) begin
				out_dir_q <= apc_pkg::DIR_RETRACT;
				out_pwm_q <= apc_pkg::PWM_STOP;
			end else begin
				out_dir_q <= tgt_gt ? apc_pkg::DIR_EXTEND : apc_pkg::DIR_RETRACT;
				out_pwm_q <= (diff < apc_pkg::SLOW_ZONE_Q) ? apc_pkg::PWM_SLOW
				                                           : apc_pkg::PWM_FULL;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_act_q;
	assign m_tdata  = {6'd0, out_len_q, out_arr_q, out_pwm_q, out_dir_q};

	`APC_ASSERT_IMP(a_arrived_stops, clk, arst_n, out_vld_q && out_arr_q, out_pwm_q == apc_pkg::PWM_STOP && out_dir_q == apc_pkg::DIR_RETRACT)
	`APC_ASSERT_IMP(a_len_clamped, clk, arst_n, out_vld_q, out_len_q <= apc_pkg::MAX_LEN_Q)
	`APC_ASSERT_NXT(a_emit_shows, clk, arst_n, cmd.emit, out_vld_q)

endmodule
`default_nettype wire

### sv/actuator_position_controller.sv
// A completing sample runs the prepare, check, divide, finish and emit states in order.
// Other transactions are taken one per cycle while idle; a completing sample holds
// the input through those states, whose 16-step restoring divider forms the length,
// plus any cycles in which the previous result still waits in the output register.
// A finished result waits in an output register while the next transaction is taken.
// Reset clears sample counts, sums, arrived flags and the output valid; config to defaults.
`default_nettype none
module actuator_position_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] sample
	input  wire logic [1:0]  s_tuser,   // [0] action, [1] actuator
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [0] direction, [8:1] pwm, [9] arrived, [25:10] length
	output logic             m_tuser,   // [0] which_actuator
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	apc_pkg::cfg_t cfg;
	apc_pkg::cmd_t cmd;
	apc_pkg::sts_t sts;

	apc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	apc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	apc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
